[rtl/mfh_pkg.sv]
// package for the mutex with fifo wait queue
// holds default sizes, status and command codes, fsm state and control structs
// no dependencies
package mfh_pkg;

   localparam int NUM_THREADS_DEF = 64;
   localparam int WAIT_DEPTH_DEF  = 64;

   // request command codes
   localparam logic CMD_ACQUIRE = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      ST_GRANTED       = 3'd0,
      ST_QUEUED        = 3'd1,
      ST_ALREADY_OWNER = 3'd2,
      ST_RELEASED_FREE = 3'd3,
      ST_HANDED_OVER   = 3'd4,
      ST_NOT_OWNER     = 3'd5,
      ST_QUEUE_FULL    = 3'd6
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic commit;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic slot_free;
   } dp_stat_type;

endpackage

[rtl/mutex_fifo_handoff.sv]
// the request word is latched when accepted; the result word is registered when it is committed
// a new request is taken only after the previous one is committed (accept, then execute/commit)
// the commit waits while the previous result word is still held by the consumer
// reset (synchronous, active high): lock free, no owner, fifo empty, no result pending
// depends on mfh_pkg, mfh_ctrl, mfh_datapath
module mutex_fifo_handoff #(
   parameter int NUM_THREADS = mfh_pkg::NUM_THREADS_DEF,
   parameter int WAIT_DEPTH  = mfh_pkg::WAIT_DEPTH_DEF,
   localparam int ID_W  = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1,
   localparam int CNT_W = $clog2(WAIT_DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_command,
   input  logic [ID_W-1:0]  req_thread_id,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [2:0]       rsp_status,
   output logic             rsp_wake_valid,
   output logic [ID_W-1:0]  rsp_wake_thread,
   output logic             rsp_lock_is_free,
   output logic [ID_W-1:0]  rsp_owner_now,
   output logic [CNT_W-1:0] rsp_waiter_count
);

   mfh_pkg::dp_cmd_type  cmd;
   mfh_pkg::dp_stat_type stat;

   mfh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   mfh_datapath #(
      .NUM_THREADS (NUM_THREADS),
      .WAIT_DEPTH  (WAIT_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_command      (req_command),
      .req_thread_id    (req_thread_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_wake_valid   (rsp_wake_valid),
      .rsp_wake_thread  (rsp_wake_thread),
      .rsp_lock_is_free (rsp_lock_is_free),
      .rsp_owner_now    (rsp_owner_now),
      .rsp_waiter_count (rsp_waiter_count)
   );

endmodule

[rtl/mfh_datapath.sv]
// datapath: request latch, lock state, waiter fifo memory and result register
// depends on mfh_pkg; driven by mfh_ctrl through dp_cmd_type
module mfh_datapath #(
   parameter int NUM_THREADS = mfh_pkg::NUM_THREADS_DEF,
   parameter int WAIT_DEPTH  = mfh_pkg::WAIT_DEPTH_DEF,
   localparam int ID_W  = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1,
   localparam int PTR_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1,
   localparam int CNT_W = $clog2(WAIT_DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  mfh_pkg::dp_cmd_type cmd,
   output mfh_pkg::dp_stat_type stat,
   input  logic                req_command,
   input  logic [ID_W-1:0]     req_thread_id,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_status,
   output logic                rsp_wake_valid,
   output logic [ID_W-1:0]     rsp_wake_thread,
   output logic                rsp_lock_is_free,
   output logic [ID_W-1:0]     rsp_owner_now,
   output logic [CNT_W-1:0]    rsp_waiter_count
);

   logic              cmd_ff;
   logic [ID_W-1:0]   tid_ff;
   logic              free_ff, free_in;
   logic [ID_W-1:0]   owner_ff, owner_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ID_W-1:0]   rd_ff;
   logic [ID_W-1:0]   mem [WAIT_DEPTH];

   logic              push;
   logic              is_owner;
   logic              full;
   mfh_pkg::status_type st_in;
   logic              wake_in;

   logic              rsp_valid_ff;
   logic [2:0]        status_ff;
   logic              wake_ff;
   logic [ID_W-1:0]   wake_tid_ff;
   logic              out_free_ff;
   logic [ID_W-1:0]   out_owner_ff;
   logic [CNT_W-1:0]  out_count_ff;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(WAIT_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_command;
         tid_ff <= req_thread_id;
      end
   end

   assign is_owner = !free_ff && (owner_ff == tid_ff);
   assign full     = (count_ff >= CNT_W'(WAIT_DEPTH));

   always_comb begin
      free_in  = free_ff;
      owner_in = owner_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      push     = 1'b0;
      wake_in  = 1'b0;
      st_in    = mfh_pkg::ST_NOT_OWNER;
      if (cmd_ff == mfh_pkg::CMD_ACQUIRE) begin
         priority if (is_owner) begin
            st_in = mfh_pkg::ST_ALREADY_OWNER;
         end else if (free_ff) begin
            free_in  = 1'b0;
            owner_in = tid_ff;
            st_in    = mfh_pkg::ST_GRANTED;
         end else if (full) begin
            st_in = mfh_pkg::ST_QUEUE_FULL;
         end else begin
            push     = 1'b1;
            tail_in  = next_ptr(tail_ff);
            count_in = count_ff + 1'b1;
            st_in    = mfh_pkg::ST_QUEUED;
         end
      end else begin
         priority if (!is_owner) begin
            st_in = mfh_pkg::ST_NOT_OWNER;
         end else if (count_ff != '0) begin
            // hand the lock to the oldest waiter
            head_in  = next_ptr(head_ff);
            count_in = count_ff - 1'b1;
            owner_in = rd_ff;
            wake_in  = 1'b1;
            st_in    = mfh_pkg::ST_HANDED_OVER;
         end else begin
            free_in  = 1'b1;
            owner_in = '0;
            st_in    = mfh_pkg::ST_RELEASED_FREE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff  <= 1'b1;
         owner_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.commit) begin
         free_ff  <= free_in;
         owner_ff <= owner_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // head word is read every cycle; the controller passes through idle after each commit
   always_ff @(posedge clock) begin
      if (cmd.commit && push) begin
         mem[tail_ff] <= tid_ff;
      end
      rd_ff <= mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff    <= st_in;
         wake_ff      <= wake_in;
         wake_tid_ff  <= wake_in ? rd_ff : '0;
         out_free_ff  <= free_in;
         out_owner_ff <= free_in ? '0 : owner_in;
         out_count_ff <= count_in;
      end
   end

   assign stat.slot_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_wake_valid   = wake_ff;
   assign rsp_wake_thread  = wake_tid_ff;
   assign rsp_lock_is_free = out_free_ff;
   assign rsp_owner_now    = out_owner_ff;
   assign rsp_waiter_count = out_count_ff;

endmodule

[rtl/mfh_ctrl.sv]
// controller fsm: takes one request word, then commits it when the result slot frees
// depends on mfh_pkg; drives mfh_datapath
module mfh_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output mfh_pkg::dp_cmd_type  cmd,
   input  mfh_pkg::dp_stat_type stat
);

   mfh_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfh_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         mfh_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = mfh_pkg::S_EXEC;
            end
         end
         mfh_pkg::S_EXEC: begin
            if (stat.slot_free) begin
               cmd.commit = 1'b1;
               state_in   = mfh_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mfh_pkg::S_IDLE;
         end
      endcase
   end

endmodule

[rtl/mfh_checker.sv]
// port-level checker for mutex_fifo_handoff, attached by bind
// depends on mfh_pkg
module mfh_checker #(
   parameter int NUM_THREADS = mfh_pkg::NUM_THREADS_DEF,
   parameter int WAIT_DEPTH  = mfh_pkg::WAIT_DEPTH_DEF,
   localparam int ID_W  = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1,
   localparam int CNT_W = $clog2(WAIT_DEPTH + 1)
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [2:0]       rsp_status,
   input logic             rsp_wake_valid,
   input logic [ID_W-1:0]  rsp_wake_thread,
   input logic             rsp_lock_is_free,
   input logic [ID_W-1:0]  rsp_owner_now,
   input logic [CNT_W-1:0] rsp_waiter_count
);

   // a stalled result word stays valid and keeps its status, owner and waiter count
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_owner_now) && $stable(rsp_waiter_count))
      else $error("result word changed while stalled");

   // wake-up only on hand-over
   a_wake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_wake_valid
         == (rsp_status == mfh_pkg::ST_HANDED_OVER)))
      else $error("wake flag disagrees with status");

   // a free lock has no owner and no waiters
   a_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lock_is_free |-> rsp_owner_now == '0 && rsp_waiter_count == '0)
      else $error("free lock with owner or waiters");

   // a grant or hand-over leaves the lock held, and a hand-over makes the woken thread the owner
   a_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == mfh_pkg::ST_GRANTED
         || rsp_status == mfh_pkg::ST_HANDED_OVER) |-> !rsp_lock_is_free
         && (rsp_status != mfh_pkg::ST_HANDED_OVER || rsp_owner_now == rsp_wake_thread))
      else $error("lock not held after grant or hand-over");

   // no request taken while the previous one is still executing
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken back to back");

endmodule

bind mutex_fifo_handoff mfh_checker #(
   .NUM_THREADS (NUM_THREADS),
   .WAIT_DEPTH  (WAIT_DEPTH)
) u_mfh_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_wake_valid   (rsp_wake_valid),
   .rsp_wake_thread  (rsp_wake_thread),
   .rsp_lock_is_free (rsp_lock_is_free),
   .rsp_owner_now    (rsp_owner_now),
   .rsp_waiter_count (rsp_waiter_count)
);

[test/mfh_checker.sv]
// scoreboard for mutex_fifo_handoff: predicts each result word from the accepted requests
// and compares it field by field with the result words the block hands out
// depends on mfh_pkg
`timescale 1ns / 1ps
module mfh_scoreboard (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_command,
   input  logic [5:0] req_thread_id,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [2:0] rsp_status,
   input  logic       rsp_wake_valid,
   input  logic [5:0] rsp_wake_thread,
   input  logic       rsp_lock_is_free,
   input  logic [5:0] rsp_owner_now,
   input  logic [6:0] rsp_waiter_count,
   output int         failures,
   output int         outstanding,
   output int         handovers,
   output int         full_rejects,
   output logic       lock_free,
   output logic [5:0] lock_owner
);

   localparam int DEPTH = mfh_pkg::WAIT_DEPTH_DEF;

   typedef struct packed {
      mfh_pkg::status_type status;
      logic       wake_valid;
      logic [5:0] wake_thread;
      logic       lock_is_free;
      logic [5:0] owner_now;
      logic [6:0] waiter_count;
   } lock_word_type;

   lock_word_type pending_words[$];
   logic [5:0] wait_ring [DEPTH];
   logic [6:0] lock_waiters;
   int         head_idx;
   int         tail_idx;

   function automatic int ring_next(input int idx);
      return (idx == DEPTH - 1) ? 0 : idx + 1;
   endfunction

   // advances the lock state by one request and returns the word it should produce
   function automatic lock_word_type apply_request(input logic cmd, input logic [5:0] tid);
      lock_word_type w;
      logic       holds;
      w = '0;
      // a free lock has no owner, even for thread 0
      holds = !lock_free && lock_owner == tid;
      if (cmd == mfh_pkg::CMD_ACQUIRE) begin
         if (holds) begin
            w.status = mfh_pkg::ST_ALREADY_OWNER;
         end else if (lock_free) begin
            lock_free  = 1'b1 ^ 1'b1;
            lock_owner = tid;
            w.status   = mfh_pkg::ST_GRANTED;
         end else if (lock_waiters >= DEPTH) begin
            w.status = mfh_pkg::ST_QUEUE_FULL;
            full_rejects++;
         end else begin
            wait_ring[tail_idx] = tid;
            tail_idx = ring_next(tail_idx);
            lock_waiters++;
            w.status = mfh_pkg::ST_QUEUED;
         end
      end else begin
         if (!holds) begin
            w.status = mfh_pkg::ST_NOT_OWNER;
         end else if (lock_waiters != 0) begin
            lock_owner    = wait_ring[head_idx];
            head_idx      = ring_next(head_idx);
            lock_waiters--;
            w.wake_valid  = 1'b1;
            w.wake_thread = lock_owner;
            w.status      = mfh_pkg::ST_HANDED_OVER;
            handovers++;
         end else begin
            lock_free  = 1'b1;
            lock_owner = '0;
            w.status   = mfh_pkg::ST_RELEASED_FREE;
         end
      end
      w.lock_is_free = lock_free;
      w.owner_now    = lock_free ? 6'd0 : lock_owner;
      w.waiter_count = lock_waiters;
      return w;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : watch
      lock_word_type want;
      if (reset) begin
         pending_words.delete();
         lock_free    = 1'b1;
         lock_owner   = '0;
         lock_waiters = '0;
         head_idx     = 0;
         tail_idx     = 0;
         failures     = 0;
         outstanding  = 0;
         handovers    = 0;
         full_rejects = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_words.size() == 0) begin
               $error("result word with none expected, status %0d", rsp_status);
               failures++;
            end else begin
               want = pending_words.pop_front();
               check_field("status", 8'(want.status), 8'(rsp_status));
               check_field("wake_valid", 8'(want.wake_valid), 8'(rsp_wake_valid));
               check_field("wake_thread", 8'(want.wake_thread), 8'(rsp_wake_thread));
               check_field("lock_is_free", 8'(want.lock_is_free), 8'(rsp_lock_is_free));
               check_field("owner_now", 8'(want.owner_now), 8'(rsp_owner_now));
               check_field("waiter_count", 8'(want.waiter_count), 8'(rsp_waiter_count));
            end
         end
         if (req_valid && req_ready)
            pending_words.push_back(apply_request(req_command, req_thread_id));
         outstanding = pending_words.size();
      end
   end

endmodule

[test/testbench.sv]
// top of the mutex_fifo_handoff test: clock, reset, request stimulus and result back-pressure
// depends on mfh_pkg, mutex_fifo_handoff and mfh_scoreboard
`timescale 1ns / 1ps
module testbench;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 200;
   localparam int SETTLE_CYCLES  = 10;
   localparam int PHASE_WORDS    = 435;
   localparam int FILL_WORDS     = 72;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_command = mfh_pkg::CMD_ACQUIRE;
   logic [5:0] req_thread_id = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic       rsp_wake_valid;
   logic [5:0] rsp_wake_thread;
   logic       rsp_lock_is_free;
   logic [5:0] rsp_owner_now;
   logic [6:0] rsp_waiter_count;

   int         failures;
   int         outstanding;
   int         handovers;
   int         full_rejects;
   logic       lock_free;
   logic [5:0] lock_owner;

   int         tx_idle_pct = 0;
   int         rx_stall_pct = 0;
   logic       hold_req = 1'b0;
   int         words_sent = 0;
   int         quiet_cycles = 0;

   always #5 clock = ~clock;

   mutex_fifo_handoff u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_thread_id   (req_thread_id),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_wake_valid  (rsp_wake_valid),
      .rsp_wake_thread (rsp_wake_thread),
      .rsp_lock_is_free(rsp_lock_is_free),
      .rsp_owner_now   (rsp_owner_now),
      .rsp_waiter_count(rsp_waiter_count)
   );

   mfh_scoreboard u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_thread_id   (req_thread_id),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_wake_valid  (rsp_wake_valid),
      .rsp_wake_thread (rsp_wake_thread),
      .rsp_lock_is_free(rsp_lock_is_free),
      .rsp_owner_now   (rsp_owner_now),
      .rsp_waiter_count(rsp_waiter_count),
      .failures        (failures),
      .outstanding     (outstanding),
      .handovers       (handovers),
      .full_rejects    (full_rejects),
      .lock_free       (lock_free),
      .lock_owner      (lock_owner)
   );

   // result side back-pressure, with a long hold-off when asked for
   initial begin
      int   hold_left;
      logic hold_seen;
      hold_left = 0;
      hold_seen = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_seen)
            hold_left = HOLD_CYCLES;
         hold_seen = hold_req;
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offers one request word and returns at the falling edge after it was taken
   task automatic send_word(input logic cmd, input logic [5:0] tid);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_command   = cmd;
      req_thread_id = tid;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic wait_drained;
      req_valid = 1'b0;
      while (outstanding != 0)
         @(negedge clock);
   endtask

   // favours releases by the owner so that hand-overs walk the wait queue
   task automatic random_request;
      int         pick;
      logic [5:0] tid;
      pick = $urandom_range(99);
      tid  = 6'($urandom_range(63));
      if ($urandom_range(3) == 0)
         tid = 6'($urandom_range(3));
      if (!lock_free && pick < 40)
         send_word(mfh_pkg::CMD_RELEASE, lock_owner);
      else if (!lock_free && pick < 48)
         send_word(mfh_pkg::CMD_ACQUIRE, lock_owner);
      else if (pick < 85)
         send_word(mfh_pkg::CMD_ACQUIRE, tid);
      else
         send_word(mfh_pkg::CMD_RELEASE, tid);
   endtask

   // runs the wait queue past full, then hands the lock down the whole queue
   task automatic fill_and_drain;
      repeat (FILL_WORDS)
         send_word(mfh_pkg::CMD_ACQUIRE, 6'($urandom_range(63)));
      while (!lock_free)
         send_word(mfh_pkg::CMD_RELEASE, lock_owner);
   endtask

   initial begin
      int phase_start;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed opening, no idling
      send_word(mfh_pkg::CMD_RELEASE, 6'd0);   // release of a free lock
      send_word(mfh_pkg::CMD_ACQUIRE, 6'd0);   // thread 0 takes the free lock
      send_word(mfh_pkg::CMD_ACQUIRE, 6'd0);
      send_word(mfh_pkg::CMD_RELEASE, 6'd63);
      send_word(mfh_pkg::CMD_ACQUIRE, 6'd63);
      send_word(mfh_pkg::CMD_ACQUIRE, 6'd63);  // same thread waits twice
      send_word(mfh_pkg::CMD_ACQUIRE, 6'd21);
      send_word(mfh_pkg::CMD_RELEASE, 6'd0);
      send_word(mfh_pkg::CMD_RELEASE, 6'd63);
      send_word(mfh_pkg::CMD_ACQUIRE, 6'd63);
      send_word(mfh_pkg::CMD_RELEASE, 6'd63);
      send_word(mfh_pkg::CMD_RELEASE, 6'd21);
      send_word(mfh_pkg::CMD_RELEASE, 6'd21);
      send_word(mfh_pkg::CMD_ACQUIRE, 6'd42);
      send_word(mfh_pkg::CMD_RELEASE, 6'd42);
      send_word(mfh_pkg::CMD_ACQUIRE, 6'd0);
      send_word(mfh_pkg::CMD_RELEASE, 6'd0);
      send_word(mfh_pkg::CMD_RELEASE, 6'd0);   // thread 0 never owns a free lock
      send_word(mfh_pkg::CMD_ACQUIRE, 6'd0);
      send_word(mfh_pkg::CMD_ACQUIRE, 6'd45);
      send_word(mfh_pkg::CMD_RELEASE, 6'd0);
      send_word(mfh_pkg::CMD_RELEASE, 6'd45);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 86; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 86; end
            default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
         endcase
         phase_start = words_sent;
         fill_and_drain();
         if (phase == 0) begin
            // sender keeps offering while results back up
            hold_req = 1'b1;
            repeat (12) random_request();
            hold_req = 1'b0;
         end
         while (words_sent - phase_start < PHASE_WORDS)
            random_request();
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("covered %0d requests over four pacing phases: %0d hand-overs, %0d full rejects",
               words_sent, handovers, full_rejects);
      if (failures == 0 && outstanding == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
